// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL; only the core top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== rtl/wis_pkg.sv =====
// Types and constants of the weighted interval schedule core.
package wis_pkg;

  localparam int MaxJobs = 32;
  localparam int PosW    = $clog2(MaxJobs + 1);
  localparam int IdxW    = $clog2(MaxJobs);
  localparam int TimeW   = 16;
  localparam int PredW   = 5;
  localparam int OptW    = 21;
  localparam logic [OptW-1:0] OptMax = {OptW{1'b1}};

  typedef struct packed {
    logic [TimeW-1:0] start;
    logic [TimeW-1:0] finish;
    logic [TimeW-1:0] weight;
  } job_t;

  typedef struct packed {
    logic [15:0] start_time;
    logic [15:0] finish_time;
    logic [15:0] job_weight;
    logic        last_job;
  } req_t;

  typedef struct packed {
    logic [5:0]  position;
    logic [15:0] sorted_start;
    logic [15:0] sorted_finish;
    logic [15:0] sorted_weight;
    logic [4:0]  pred_index;
    logic [20:0] best_value;
    logic        chosen;
    logic        overflow;
    logic        last_result;
  } res_t;

  // Sort carry moving down the chain.
  typedef struct packed {
    logic valid;
    job_t job;
  } carry_t;

  // Predecessor probe moving down the chain.
  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] start;
    logic [PosW-1:0]  idx;
    logic [PredW-1:0] cnt;
  } probe_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic            wr_en;
    job_t            wr_job;
    logic [PosW-1:0] job_total;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_INJ,
    ST_SORT_WAIT,
    ST_PRED_RUN,
    ST_PRED_WAIT,
    ST_DP_INIT,
    ST_DP_RD,
    ST_DP_WR,
    ST_TRACE,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT_SEND
  } state_t;

endpackage

// ===== rtl/wis_cell.sv =====
// One chain cell: holds a job, swaps with a passing sort carry, counts probes.
module wis_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [wis_pkg::PosW-1:0] cell_pos,
  input  wis_pkg::cell_ctl_t       ctl,
  input  wis_pkg::carry_t          carry_in,
  output wis_pkg::carry_t          carry_out,
  input  wis_pkg::probe_t          probe_in,
  output wis_pkg::probe_t          probe_out,
  output wis_pkg::job_t            job
);

  logic active;
  logic swap;
  logic hit;

  assign active = cell_pos <= ctl.job_total;
  assign swap   = carry_in.valid && active && (carry_in.job.finish > job.finish);
  assign hit    = probe_in.valid && (cell_pos < probe_in.idx)
                  && (job.finish <= probe_in.start);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      job <= ctl.wr_job;
    end else if (swap) begin
      job <= carry_in.job;
    end
    // keep the larger finish, hand the smaller one on
    carry_out.job   <= swap ? job : carry_in.job;
    probe_out.start <= probe_in.start;
    probe_out.idx   <= probe_in.idx;
    probe_out.cnt   <= probe_in.cnt + wis_pkg::PredW'(hit);
    if (rst) begin
      carry_out.valid <= 1'b0;
      probe_out.valid <= 1'b0;
    end else begin
      carry_out.valid <= carry_in.valid;
      probe_out.valid <= probe_in.valid;
    end
  end

endmodule

// ===== rtl/weighted_interval_schedule_core.sv =====
// Top level of the weighted interval schedule core.
// Usage:
//   Requests (req_valid/req_ready, req_data) carry one interval each:
//   start, finish, weight. The request with last_job set closes the set.
//   Up to 32 intervals are kept; later requests are dropped and flag overflow.
//   req_ready is high only while the set is being loaded: one request a cycle.
//   After the close the block sorts by finish time, finds predecessors,
//   runs the optimum recurrence, traces the chosen set and then sends one
//   result per sorted position on res_valid/res_ready, res_data, in order.
// Phases:
//   Sort: for n intervals, n-1 passes of a carry through the 32-cell chain;
//   each pass ends when the carry leaves the last cell.
//   Predecessors: n probes enter the chain one a cycle, done when the last exits.
//   Recurrence: per position an opt memory read, then a write.
//   Trace: follows chosen positions back to zero. Results: each is read,
//   captured and then held until taken before the next is read.
// Reset clears the sequencer, counts and flags; the chain data needs none.
// A stalled receiver holds the result register steady; no work is lost.
`include "assert_macros.svh"

module weighted_interval_schedule_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  wis_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_ready,
  output wis_pkg::res_t res_data
);

  localparam int N = wis_pkg::MaxJobs;

  wis_pkg::state_t state, state_next;

  logic [wis_pkg::PosW-1:0]  job_count;
  logic [wis_pkg::PosW-1:0]  job_total;
  logic                      overflow_flag;
  logic [wis_pkg::PosW-1:0]  ptr;
  logic [wis_pkg::PosW-1:0]  trace_pos;
  logic [wis_pkg::IdxW-1:0]  ptr_idx;

  // chain wiring
  wis_pkg::carry_t    carry_i [N];
  wis_pkg::carry_t    carry_o [N];
  wis_pkg::probe_t    probe_i [N];
  wis_pkg::probe_t    probe_o [N];
  wis_pkg::job_t      cell_job [N];
  wis_pkg::cell_ctl_t cell_ctl [N];

  // sequencer controls
  logic                     load_we;
  logic [wis_pkg::IdxW-1:0] load_idx;
  wis_pkg::job_t            load_job;
  logic                     carry_inject;
  logic                     probe_inject;
  wis_pkg::job_t            sel_job;

  // per-position results
  logic [wis_pkg::PredW-1:0] pred_store [N];
  logic [N-1:0]              gain_mask;
  logic [N-1:0]              chosen_mask;
  logic [wis_pkg::OptW-1:0]  opt_prev;

  // opt memory, entry zero rewritten to zero for each set
  logic [wis_pkg::OptW-1:0] opt_mem [N+1];
  logic                     mem_we;
  logic [wis_pkg::PosW-1:0] mem_wa;
  logic [wis_pkg::OptW-1:0] mem_wd;
  logic                     mem_re;
  logic [wis_pkg::PosW-1:0] mem_ra;
  logic [wis_pkg::OptW-1:0] mem_rd;

  logic                     req_fire;
  logic                     res_fire;
  logic                     room;
  logic [wis_pkg::PosW-1:0] count_after;
  logic [wis_pkg::OptW:0]   take_sum;
  logic [wis_pkg::OptW-1:0] take_val;
  logic [wis_pkg::OptW-1:0] opt_val;
  logic [wis_pkg::IdxW-1:0] trace_idx;
  logic [wis_pkg::IdxW-1:0] exit_idx;

  assign req_fire    = req_valid && req_ready;
  assign res_fire    = res_valid && res_ready;
  assign room        = job_count < wis_pkg::PosW'(N);
  assign count_after = job_count + wis_pkg::PosW'(room);
  assign ptr_idx     = wis_pkg::IdxW'(ptr - 1'b1);
  assign trace_idx   = wis_pkg::IdxW'(trace_pos - 1'b1);
  assign exit_idx    = wis_pkg::IdxW'(probe_o[N-1].idx - 1'b1);
  assign sel_job     = cell_job[ptr_idx];

  // recurrence: take = weight + opt[pred], saturated
  assign take_sum = (wis_pkg::OptW+1)'(sel_job.weight) + (wis_pkg::OptW+1)'(mem_rd);
  assign take_val = (take_sum > (wis_pkg::OptW+1)'(wis_pkg::OptMax)) ? wis_pkg::OptMax
                                                                     : take_sum[wis_pkg::OptW-1:0];
  assign opt_val  = (take_val > opt_prev) ? take_val : opt_prev;

  // chain of cells
  always_comb begin
    for (int k = 0; k < N; k++) begin
      cell_ctl[k].wr_en     = load_we && (load_idx == wis_pkg::IdxW'(k));
      cell_ctl[k].wr_job    = load_job;
      cell_ctl[k].job_total = job_total;
      if (carry_inject && (ptr[wis_pkg::IdxW-1:0] == wis_pkg::IdxW'(k))) begin
        carry_i[k].valid = 1'b1;
        carry_i[k].job   = sel_job;
      end else if (k == 0) begin
        carry_i[k] = '0;
      end else begin
        carry_i[k] = carry_o[k-1];
      end
      if (k == 0) begin
        probe_i[k].valid = probe_inject;
        probe_i[k].start = sel_job.start;
        probe_i[k].idx   = ptr;
        probe_i[k].cnt   = '0;
      end else begin
        probe_i[k] = probe_o[k-1];
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    wis_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_pos  (wis_pkg::PosW'(k + 1)),
      .ctl       (cell_ctl[k]),
      .carry_in  (carry_i[k]),
      .carry_out (carry_o[k]),
      .probe_in  (probe_i[k]),
      .probe_out (probe_o[k]),
      .job       (cell_job[k])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wis_pkg::ST_LOAD: begin
        if (req_fire && req_data.last_job) begin
          state_next = (count_after > wis_pkg::PosW'(1)) ? wis_pkg::ST_SORT_INJ
                                                         : wis_pkg::ST_PRED_RUN;
        end
      end
      wis_pkg::ST_SORT_INJ:  state_next = wis_pkg::ST_SORT_WAIT;
      wis_pkg::ST_SORT_WAIT: begin
        if (carry_o[N-1].valid) begin
          state_next = (ptr + 1'b1 == job_total) ? wis_pkg::ST_PRED_RUN
                                                 : wis_pkg::ST_SORT_INJ;
        end
      end
      wis_pkg::ST_PRED_RUN: begin
        if (ptr == job_total) state_next = wis_pkg::ST_PRED_WAIT;
      end
      wis_pkg::ST_PRED_WAIT: begin
        if (probe_o[N-1].valid && probe_o[N-1].idx == job_total) begin
          state_next = wis_pkg::ST_DP_INIT;
        end
      end
      wis_pkg::ST_DP_INIT: state_next = wis_pkg::ST_DP_RD;
      wis_pkg::ST_DP_RD:   state_next = wis_pkg::ST_DP_WR;
      wis_pkg::ST_DP_WR: begin
        state_next = (ptr == job_total) ? wis_pkg::ST_TRACE : wis_pkg::ST_DP_RD;
      end
      wis_pkg::ST_TRACE: begin
        if (trace_pos == '0) state_next = wis_pkg::ST_OUT_RD;
      end
      wis_pkg::ST_OUT_RD:  state_next = wis_pkg::ST_OUT_CAP;
      wis_pkg::ST_OUT_CAP: state_next = wis_pkg::ST_OUT_SEND;
      wis_pkg::ST_OUT_SEND: begin
        if (res_ready) begin
          state_next = (ptr == job_total) ? wis_pkg::ST_LOAD : wis_pkg::ST_OUT_RD;
        end
      end
      default: state_next = wis_pkg::ST_LOAD;
    endcase
  end

  // controls
  always_comb begin
    req_ready    = 1'b0;
    res_valid    = 1'b0;
    load_we      = 1'b0;
    load_idx     = job_count[wis_pkg::IdxW-1:0];
    load_job     = '0;
    carry_inject = 1'b0;
    probe_inject = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = ptr;
    mem_wd       = opt_val;
    mem_re       = 1'b0;
    mem_ra       = ptr;
    case (state)
      wis_pkg::ST_LOAD: begin
        req_ready       = 1'b1;
        load_we         = req_fire && room;
        load_job.start  = req_data.start_time;
        load_job.finish = req_data.finish_time;
        load_job.weight = req_data.job_weight;
      end
      wis_pkg::ST_SORT_INJ: carry_inject = 1'b1;
      wis_pkg::ST_SORT_WAIT: begin
        // write the pass minimum back to its position
        load_we  = carry_o[N-1].valid;
        load_idx = ptr_idx;
        load_job = carry_o[N-1].job;
      end
      wis_pkg::ST_PRED_RUN: probe_inject = 1'b1;
      wis_pkg::ST_DP_INIT: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = '0;
      end
      wis_pkg::ST_DP_RD: begin
        mem_re = 1'b1;
        mem_ra = wis_pkg::PosW'(pred_store[ptr_idx]);
      end
      wis_pkg::ST_DP_WR:    mem_we = 1'b1;
      wis_pkg::ST_OUT_RD:   mem_re = 1'b1;
      wis_pkg::ST_OUT_SEND: res_valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) opt_mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd <= opt_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (probe_o[N-1].valid) pred_store[exit_idx] <= probe_o[N-1].cnt;
    if (state == wis_pkg::ST_OUT_CAP) begin
      res_data.position      <= ptr;
      res_data.sorted_start  <= sel_job.start;
      res_data.sorted_finish <= sel_job.finish;
      res_data.sorted_weight <= sel_job.weight;
      res_data.pred_index    <= pred_store[ptr_idx];
      res_data.best_value    <= mem_rd;
      res_data.chosen        <= chosen_mask[ptr_idx];
      res_data.overflow      <= overflow_flag;
      res_data.last_result   <= ptr == job_total;
    end
    if (rst) begin
      state         <= wis_pkg::ST_LOAD;
      job_count     <= '0;
      job_total     <= '0;
      overflow_flag <= 1'b0;
      ptr           <= '0;
      trace_pos     <= '0;
      opt_prev      <= '0;
      gain_mask     <= '0;
      chosen_mask   <= '0;
    end else begin
      state <= state_next;
      case (state)
        wis_pkg::ST_LOAD: begin
          if (req_fire) begin
            if (!room) overflow_flag <= 1'b1;
            if (req_data.last_job) begin
              job_total <= count_after;
              job_count <= '0;
              ptr       <= wis_pkg::PosW'(1);
            end else begin
              job_count <= count_after;
            end
          end
        end
        wis_pkg::ST_SORT_WAIT: begin
          if (carry_o[N-1].valid) begin
            ptr <= (ptr + 1'b1 == job_total) ? wis_pkg::PosW'(1) : ptr + 1'b1;
          end
        end
        wis_pkg::ST_PRED_RUN: begin
          if (ptr != job_total) ptr <= ptr + 1'b1;
        end
        wis_pkg::ST_DP_INIT: begin
          ptr         <= wis_pkg::PosW'(1);
          opt_prev    <= '0;
          gain_mask   <= '0;
          chosen_mask <= '0;
        end
        wis_pkg::ST_DP_WR: begin
          gain_mask[ptr_idx] <= take_val > opt_prev;
          opt_prev           <= opt_val;
          if (ptr == job_total) begin
            trace_pos <= job_total;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        wis_pkg::ST_TRACE: begin
          // follow predecessors from the last position back
          if (trace_pos == '0) begin
            ptr <= wis_pkg::PosW'(1);
          end else if (gain_mask[trace_idx]) begin
            chosen_mask[trace_idx] <= 1'b1;
            trace_pos              <= wis_pkg::PosW'(pred_store[trace_idx]);
          end else begin
            trace_pos <= trace_pos - 1'b1;
          end
        end
        wis_pkg::ST_OUT_SEND: begin
          if (res_ready) begin
            if (ptr == job_total) begin
              overflow_flag <= 1'b0;
            end else begin
              ptr <= ptr + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_CLK(a_no_overlap, !(req_ready && res_valid))
  `ASSERT_CLK(a_count_bound, job_count <= wis_pkg::PosW'(N))
  `ASSERT_CLK(a_back_to_load, (res_fire && res_data.last_result) |=> req_ready)
  `ASSERT_CLK(a_total_set, (state == wis_pkg::ST_DP_INIT) |-> (job_total != '0))

endmodule

// ===== sim/weighted_interval_schedule_core_tb.sv =====
// Self-checking testbench for the weighted interval schedule core.
module weighted_interval_schedule_core_tb;

  localparam int WatchLimit = 20000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  wis_pkg::req_t req_data;
  logic res_valid;
  logic res_ready;
  wis_pkg::res_t res_data;

  weighted_interval_schedule_core u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data(res_data)
  );

  // Requests waiting for the driver, and schedule results still owed.
  wis_pkg::req_t pending_reqs[$];
  wis_pkg::res_t owed_results[$];

  // Predictor copy of the interval set being loaded.
  wis_pkg::job_t set_jobs[1:wis_pkg::MaxJobs];
  int   set_count = 0;
  bit   set_overflow = 1'b0;

  int  errors = 0;
  int  req_sent = 0;
  int  res_seen = 0;
  int  sets_closed = 0;
  int  overflow_sets = 0;
  int  idle_cycles = 0;
  bit  hold_res = 1'b0;

  // Set at the rising edge when the request in flight was taken.
  bit req_ready_seen = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, res_seen);
    errors++;
  endtask

  // Sort the set by finish, solve the schedule and queue one result per position.
  task automatic schedule_set();
    wis_pkg::job_t jobs[0:wis_pkg::MaxJobs];
    int            pred[0:wis_pkg::MaxJobs];
    int            opt[0:wis_pkg::MaxJobs];
    bit            pick[0:wis_pkg::MaxJobs];
    wis_pkg::job_t tmp;
    int            n;
    int            take;
    int            x;
    wis_pkg::res_t r;
    n = set_count;
    jobs[0] = '0;
    for (int i = 1; i <= n; i++) jobs[i] = set_jobs[i];
    for (int i = 1; i < n; i++)
      for (int j = i + 1; j <= n; j++)
        if (jobs[i].finish > jobs[j].finish) begin
          tmp = jobs[i];
          jobs[i] = jobs[j];
          jobs[j] = tmp;
        end
    opt[0] = 0;
    pred[0] = 0;
    for (int i = 1; i <= n; i++) begin
      pred[i] = 0;
      for (int j = i - 1; j >= 0; j--)
        if (jobs[j].finish <= jobs[i].start) begin
          pred[i] = j;
          break;
        end
    end
    for (int i = 0; i <= n; i++) pick[i] = 1'b0;
    for (int i = 1; i <= n; i++) begin
      take = int'(jobs[i].weight) + opt[pred[i]];
      if (take > int'(wis_pkg::OptMax)) take = int'(wis_pkg::OptMax);
      opt[i] = (take > opt[i-1]) ? take : opt[i-1];
    end
    x = n;
    while (x != 0) begin
      take = int'(jobs[x].weight) + opt[pred[x]];
      if (take > int'(wis_pkg::OptMax)) take = int'(wis_pkg::OptMax);
      if (take > opt[x-1]) begin
        pick[x] = 1'b1;
        x = pred[x];
      end else begin
        x = x - 1;
      end
    end
    for (int i = 1; i <= n; i++) begin
      r.position      = 6'(i);
      r.sorted_start  = jobs[i].start;
      r.sorted_finish = jobs[i].finish;
      r.sorted_weight = jobs[i].weight;
      r.pred_index    = 5'(pred[i]);
      r.best_value    = 21'(opt[i]);
      r.chosen        = pick[i];
      r.overflow      = set_overflow;
      r.last_result   = (i == n);
      owed_results.push_back(r);
    end
    if (set_overflow) overflow_sets++;
    sets_closed++;
    set_count = 0;
    set_overflow = 1'b0;
  endtask

  // Store or drop one accepted request; close the set on last_job.
  task automatic accept_request(input wis_pkg::req_t q);
    if (set_count < wis_pkg::MaxJobs) begin
      set_count++;
      set_jobs[set_count] = '{start: q.start_time, finish: q.finish_time,
                              weight: q.job_weight};
    end else begin
      set_overflow = 1'b1;
    end
    if (q.last_job) schedule_set();
  endtask

  function automatic logic [15:0] rand_time();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Queue one set of n intervals; if not wide, times cluster so overlaps matter.
  task automatic queue_set(input int n, input bit wide);
    wis_pkg::req_t q;
    int            base;
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        q.start_time  = rand_time();
        q.finish_time = rand_time();
      end else begin
        base = $urandom_range(0, 200);
        q.start_time  = 16'(base);
        q.finish_time = 16'(base + $urandom_range(0, 60));
      end
      q.job_weight = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      q.last_job   = (i == n - 1);
      pending_reqs.push_back(q);
    end
  endtask

  // Driver: advance to the next request at the falling edge, with random gaps.
  int gap_left;
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_data  <= '0;
      gap_left  <= 0;
    end else if (!req_valid || (req_valid && req_ready_seen)) begin
      if (gap_left > 0) begin
        req_valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        req_data  <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        gap_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
                     ($urandom_range(0, 1) ? 0 : $urandom_range(0, 2));
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: sample both handshakes at the rising edge and check results.
  always @(posedge clk) begin
    wis_pkg::res_t w;
    if (rst) begin
      req_ready_seen <= 1'b0;
    end else begin
      req_ready_seen <= req_valid && req_ready;
      if ((req_valid && req_ready) || (res_valid && res_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (req_valid && req_ready) begin
        accept_request(req_data);
        req_sent++;
      end
      if (res_valid && res_ready) begin
        if (owed_results.size() == 0) begin
          $display("unexpected result at position %0d", res_data.position);
          errors++;
        end else begin
          w = owed_results.pop_front();
          if (res_data.position != w.position)
            report_mismatch("position", int'(res_data.position), int'(w.position));
          if (res_data.sorted_start != w.sorted_start)
            report_mismatch("sorted_start", int'(res_data.sorted_start),
                            int'(w.sorted_start));
          if (res_data.sorted_finish != w.sorted_finish)
            report_mismatch("sorted_finish", int'(res_data.sorted_finish),
                            int'(w.sorted_finish));
          if (res_data.sorted_weight != w.sorted_weight)
            report_mismatch("sorted_weight", int'(res_data.sorted_weight),
                            int'(w.sorted_weight));
          if (res_data.pred_index != w.pred_index)
            report_mismatch("pred_index", int'(res_data.pred_index), int'(w.pred_index));
          if (res_data.best_value != w.best_value)
            report_mismatch("best_value", int'(res_data.best_value), int'(w.best_value));
          if (res_data.chosen != w.chosen)
            report_mismatch("chosen", int'(res_data.chosen), int'(w.chosen));
          if (res_data.overflow != w.overflow)
            report_mismatch("overflow", int'(res_data.overflow), int'(w.overflow));
          if (res_data.last_result != w.last_result)
            report_mismatch("last_result", int'(res_data.last_result),
                            int'(w.last_result));
        end
        res_seen++;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off while hold_res is set.
  int stall_left;
  always @(negedge clk) begin
    if (rst) begin
      res_ready  <= 1'b0;
      stall_left <= 0;
    end else if (hold_res) begin
      res_ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 12) == 0) ? $urandom_range(10, 40) :
                      $urandom_range(1, 3);
    end
  end

  // Watchdog: stop when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst && idle_cycles >= WatchLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAIL weighted_interval_schedule_core");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || owed_results.size() > 0 || req_valid)
      @(posedge clk);
  endtask

  initial begin
    wis_pkg::req_t q;
    int            n;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extreme singles, zero-weight ties, equal finishes; full wide set.
    pending_reqs.push_back('{start_time: 16'hFFFF, finish_time: 16'hFFFF,
                             job_weight: 16'hFFFF, last_job: 1'b1});
    pending_reqs.push_back('{start_time: 16'h0, finish_time: 16'h0,
                             job_weight: 16'h0, last_job: 1'b1});
    pending_reqs.push_back('{start_time: 16'd0, finish_time: 16'd10,
                             job_weight: 16'd5, last_job: 1'b0});
    pending_reqs.push_back('{start_time: 16'd2, finish_time: 16'd10,
                             job_weight: 16'd5, last_job: 1'b0});
    pending_reqs.push_back('{start_time: 16'd10, finish_time: 16'd20,
                             job_weight: 16'd0, last_job: 1'b0});
    pending_reqs.push_back('{start_time: 16'd30, finish_time: 16'd5,
                             job_weight: 16'd9, last_job: 1'b1});
    queue_set(wis_pkg::MaxJobs, 1'b1);
    wait_drained();

    // Overflow: a full set plus dropped extras, one of them closing the set.
    // Hold off results long enough for the block to back up.
    queue_set(wis_pkg::MaxJobs, 1'b0);
    pending_reqs[pending_reqs.size()-1].last_job = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q.start_time = rand_time();
      q.finish_time = rand_time();
      q.job_weight = 16'($urandom_range(0, 65535));
      q.last_job = (i == 2);
      pending_reqs.push_back(q);
    end
    queue_set(4, 1'b0);
    hold_res = 1'b1;
    repeat (1500) @(posedge clk);
    hold_res = 1'b0;
    wait_drained();

    // Random sets, mostly small.
    while (req_sent < 250) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, wis_pkg::MaxJobs)
                                       : $urandom_range(1, 8);
      queue_set(n, $urandom_range(0, 3) == 0);
      wait_drained();
    end

    repeat (200) @(posedge clk);
    $display("sent %0d requests in %0d sets (%0d with overflow), checked %0d results",
             req_sent, sets_closed, overflow_sets, res_seen);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("PASS weighted_interval_schedule_core");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, owed_results.size());
      $display("FAIL weighted_interval_schedule_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wis_pkg.sv
rtl/wis_cell.sv
rtl/weighted_interval_schedule_core.sv
sim/weighted_interval_schedule_core_tb.sv
